>>> hw/rtl/tss_pkg.sv
// shared types, constants and helpers for the threshold sweep metrics block
// no dependencies; imported by every module of the block except tss_div
package tss_pkg;

  localparam int THRESHOLD_COUNT_DEF = 17;
  localparam int MAX_CLASSES_DEF     = 16;
  localparam int COUNTER_BITS_DEF    = 32;
  localparam int PROB_BITS_DEF       = 16;

  localparam int QUEUE_DEPTH    = 4;
  localparam int IN_TDATA_BITS  = 24;
  localparam int OUT_TDATA_BITS = 104;

  // configuration register indexes
  localparam logic [1:0] CFG_CLASS_COUNT = 2'd0;
  localparam logic [1:0] CFG_THR_START   = 2'd1;
  localparam logic [1:0] CFG_THR_STRIDE  = 2'd2;

  localparam logic [4:0]  CLASS_COUNT_RST = 5'd1;
  localparam logic [15:0] THR_START_RST   = 16'd6554;
  localparam logic [15:0] THR_STRIDE_RST  = 16'd3277;

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  typedef enum logic {
    KIND_ACCUM,
    KIND_FINISH
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  cls;
    logic        tgt;
    logic [15:0] prob;
  } item_t;

  // packed so that mean_iou sits in the lowest bits
  typedef struct packed {
    logic        any_valid;
    logic [4:0]  chosen_index;
    logic [15:0] chosen_threshold;
    logic [15:0] pixel_accuracy;
    logic [15:0] f1_score;
    logic [15:0] mean_recall;
    logic [15:0] mean_precision;
    logic [15:0] mean_iou;
  } result_t;

  typedef enum logic [3:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_ACC,
    BK_F_READ,
    BK_F_LOAD,
    BK_F_RATIO,
    BK_F_RWAIT,
    BK_F_MEAN,
    BK_F_MWAIT,
    BK_F_NEXT,
    BK_F_ACC,
    BK_F_AWAIT,
    BK_F_EMIT
  } back_state_t;

  function automatic logic [15:0] sat16(input logic [16:0] v);
    return v[16] ? 16'hFFFF : v[15:0];
  endfunction

endpackage

>>> hw/rtl/threshold_sweep_segmentation_metrics.sv
// channel  | dir | handshake                  | payload
// s_       | in  | s_tvalid / s_tready        | s_tdata elements, s_tuser command
// m_       | out | m_tvalid / m_tready        | m_tdata one result per finish
// cfg_     | in  | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// an accumulate beat does, in the back end, one read-modify-write per threshold
// through the single port pair of the count memory
// a finish beat takes about THRESHOLD_COUNT * (classes * 3 + 4) divides in the
// shared divider, then a clear pass
// the clear pass after reset and after each finish zeroes all THRESHOLD_COUNT *
// MAX_CLASSES entries while queued beats wait; reset is synchronous, active high
// s_tready falls only when the four-entry queue is full; results wait in m_tdata
//
// top level; depends on tss_pkg, tss_front, tss_back
module threshold_sweep_segmentation_metrics #(
  parameter int THRESHOLD_COUNT = tss_pkg::THRESHOLD_COUNT_DEF,
  parameter int MAX_CLASSES     = tss_pkg::MAX_CLASSES_DEF,
  parameter int COUNTER_BITS    = tss_pkg::COUNTER_BITS_DEF,
  parameter int PROB_BITS       = tss_pkg::PROB_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // probability[15:0], target_bit[16], class_index[20:17], zero[23:21]
  input  logic [tss_pkg::IN_TDATA_BITS-1:0]   s_tdata,
  // cmd[0]
  input  logic [0:0]                          s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // mean_iou[15:0], mean_precision[31:16], mean_recall[47:32], f1_score[63:48],
  // pixel_accuracy[79:64], chosen_threshold[95:80], chosen_index[100:96],
  // any_valid[101], zero[103:102]
  output logic [tss_pkg::OUT_TDATA_BITS-1:0]  m_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [1:0]                          cfg_index,
  input  logic [15:0]                         cfg_data
);
  import tss_pkg::*;

  logic [4:0]  class_count;
  logic [15:0] thr_start;
  logic [15:0] thr_stride;
  logic [4:0]  class_limit;
  item_t       in_item;
  item_t       q_item;
  logic        q_valid;
  logic        q_pop;
  logic        res_valid;
  logic        res_ready;
  result_t     res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      class_count <= CLASS_COUNT_RST;
      thr_start   <= THR_START_RST;
      thr_stride  <= THR_STRIDE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CLASS_COUNT: class_count <= cfg_data[4:0];
        CFG_THR_START:   thr_start   <= cfg_data;
        CFG_THR_STRIDE:  thr_stride  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign class_limit = (32'(class_count) > MAX_CLASSES) ? 5'(MAX_CLASSES) : class_count;

  always_comb begin
    in_item.kind = s_tuser[0] ? KIND_FINISH : KIND_ACCUM;
    in_item.prob = s_tdata[15:0];
    in_item.tgt  = s_tdata[16];
    in_item.cls  = s_tdata[20:17];
  end

  tss_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_item     (in_item),
    .class_limit (class_limit),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop)
  );

  tss_back #(
    .THRESHOLD_COUNT (THRESHOLD_COUNT),
    .MAX_CLASSES     (MAX_CLASSES),
    .COUNTER_BITS    (COUNTER_BITS),
    .PROB_BITS       (PROB_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .class_limit (class_limit),
    .thr_start   (thr_start),
    .thr_stride  (thr_stride),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  // output register
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) m_tdata <= {2'b00, res};
  end

endmodule

>>> hw/rtl/tss_front.sv
// front end: takes input beats, drops out-of-range elements, queues the rest
// depends on tss_pkg
module tss_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  tss_pkg::item_t in_item,
  input  logic [4:0]     class_limit,
  output logic           q_valid,
  output tss_pkg::item_t q_item,
  input  logic           q_pop
);
  import tss_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam logic [PW:0] FULL = (PW+1)'(QUEUE_DEPTH);

  item_t          slots [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [PW:0]    fill;
  logic           keep;
  logic           push;
  logic           pop;

  assign in_ready = (fill != FULL);
  // an element of a class beyond the active count touches nothing
  assign keep     = (in_item.kind == KIND_FINISH) || ({1'b0, in_item.cls} < class_limit);
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (fill != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= in_item;
  end

endmodule

>>> hw/rtl/tss_div.sv
// restoring divider, one quotient bit per cycle
// no package dependencies; shared by all ratios of the back end
module tss_div #(
  parameter int NUM_BITS = 48,
  parameter int DEN_BITS = 33
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  output logic                done,
  output logic [NUM_BITS-1:0] quot
);

  localparam int CNTW = $clog2(NUM_BITS + 1);

  logic [DEN_BITS:0]   rem;
  logic [DEN_BITS:0]   rem_sh;
  logic [DEN_BITS-1:0] dvs;
  logic [CNTW-1:0]     steps;
  logic                busy;
  logic                fits;

  assign rem_sh = {rem[DEN_BITS-1:0], quot[NUM_BITS-1]};
  assign fits   = (rem_sh >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= CNTW'(NUM_BITS);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= num;
      dvs  <= den;
    end else if (busy) begin
      rem  <= fits ? (rem_sh - {1'b0, dvs}) : rem_sh;
      quot <= {quot[NUM_BITS-2:0], fits};
    end
  end

endmodule

>>> hw/rtl/tss_back.sv
// back end: counter memories, per-element update sweep, finish evaluation
// depends on tss_pkg and tss_div
module tss_back #(
  parameter int THRESHOLD_COUNT = tss_pkg::THRESHOLD_COUNT_DEF,
  parameter int MAX_CLASSES     = tss_pkg::MAX_CLASSES_DEF,
  parameter int COUNTER_BITS    = tss_pkg::COUNTER_BITS_DEF,
  parameter int PROB_BITS       = tss_pkg::PROB_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  tss_pkg::item_t   q_item,
  output logic             q_pop,
  input  logic [4:0]       class_limit,
  input  logic [15:0]      thr_start,
  input  logic [15:0]      thr_stride,
  output logic             res_valid,
  input  logic             res_ready,
  output tss_pkg::result_t res
);
  import tss_pkg::*;

  localparam int T     = THRESHOLD_COUNT;
  localparam int MC    = MAX_CLASSES;
  localparam int CB    = COUNTER_BITS;
  localparam int DEPTH = T * MC;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = (MC > 1) ? $clog2(MC) : 1;
  localparam int TIW   = (T > 1) ? $clog2(T) : 1;
  localparam int THW   = ((PROB_BITS > 16) ? PROB_BITS : 16) + 1;
  localparam int XW    = THW + 6;
  localparam int NW    = (CB + 16 > 34) ? CB + 16 : 34;
  localparam int DW    = (CB + 1 > 18) ? CB + 1 : 18;
  localparam int SW    = 21;

  localparam logic [THW-1:0] PMAX      = THW'((64'd1 << PROB_BITS) - 64'd1);
  localparam logic [4:0]     MID       = 5'(T / 2);
  localparam logic [4:0]     LAST_T    = 5'(T - 1);
  localparam logic [AW-1:0]  LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [AW-1:0]  MC_STEP   = AW'(MC);
  localparam logic [CB-1:0]  CNT_MAX   = '1;

  back_state_t state, state_next;

  // tp in the upper half, predicted count in the lower half
  logic [2*CB-1:0] cnt_mem [DEPTH];
  logic [2*CB-1:0] mem_q;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   wr_addr;
  logic [2*CB-1:0] wr_data;
  logic            wr_en;
  logic [CB-1:0]   tgt_mem [MC];
  logic [CB-1:0]   tgt_q;
  logic [CW-1:0]   tgt_rd_addr;
  logic [CW-1:0]   tgt_wr_addr;
  logic [CB-1:0]   tgt_wr_data;
  logic            tgt_wr_en;
  logic [CB-1:0]   mem_tp;
  logic [CB-1:0]   mem_pr;

  logic [THW-1:0]  acc_prob;
  logic            acc_tgt;
  logic [CW-1:0]   acc_cls;
  logic [AW-1:0]   acc_addr;
  logic [THW-1:0]  thr;
  logic [THW-1:0]  thr_sum;
  logic [THW-1:0]  thr_adv;
  logic [THW-1:0]  thr_init;
  logic [THW-1:0]  prob_m;
  logic            pred;
  logic [4:0]      t;
  logic            pw_en;
  logic [AW-1:0]   pw_addr;
  logic            pw_tp;
  logic            tg_pend;
  logic [CB-1:0]   match [T];
  logic [CB-1:0]   total;
  logic [CB-1:0]   m_sel;

  logic [AW-1:0]   base;
  logic [4:0]      c;
  logic [1:0]      op;
  logic [1:0]      mop;
  logic [5:0]      vcnt;
  logic [CB-1:0]   tp_r;
  logic [CB-1:0]   pr_r;
  logic [CB-1:0]   tg_r;
  logic [CB-1:0]   tp_min1;
  logic [CB-1:0]   tp_min;
  logic [CB:0]     union_cnt;
  logic [CB:0]     op_den;
  logic            ratio_special;
  logic [SW-1:0]   sums [3];
  logic [16:0]     means [4];
  logic [16:0]     best [4];
  logic            found;
  logic [4:0]      best_idx;
  logic            better;
  logic [17:0]     pr_sum;
  logic [33:0]     pr_prod;
  logic [16:0]     acc_q;
  logic [15:0]     chosen_thr;
  logic [XW-1:0]   thr_full;
  logic [XW-1:0]   thr_lim;
  logic [AW-1:0]   clr;
  logic            acc_div;

  logic            div_start;
  logic [NW-1:0]   div_num;
  logic [DW-1:0]   div_den;
  logic            div_done;
  logic [NW-1:0]   div_quot;

  tss_div #(.NUM_BITS(NW), .DEN_BITS(DW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // datapath helpers
  assign prob_m    = THW'(q_item.prob) & PMAX;
  assign thr_init  = (THW'(thr_start) > PMAX) ? PMAX : THW'(thr_start);
  assign thr_sum   = thr + THW'(thr_stride);
  assign thr_adv   = (thr_sum > PMAX) ? PMAX : thr_sum;
  assign pred      = (acc_prob > thr);
  assign mem_tp    = mem_q[2*CB-1:CB];
  assign mem_pr    = mem_q[CB-1:0];
  assign tp_min1   = (mem_tp < mem_pr) ? mem_tp : mem_pr;
  assign tp_min    = (tp_min1 < tgt_q) ? tp_min1 : tgt_q;
  assign union_cnt = (CB+1)'(pr_r) + (CB+1)'(tg_r) - (CB+1)'(tp_r);
  assign pr_sum    = 18'(means[0]) + 18'(means[1]);
  assign pr_prod   = 34'(means[0]) * 34'(means[1]);
  assign better    = (vcnt != '0) && (means[3] > best[3]);
  assign m_sel     = match[TIW'(best_idx)];
  assign acc_div   = (total != '0) && (m_sel < total);
  assign thr_full  = XW'(thr_start) + XW'(best_idx) * XW'(thr_stride);
  assign thr_lim   = (thr_full > XW'(PMAX)) ? XW'(PMAX) : thr_full;

  always_comb begin
    case (op)
      2'd0:    op_den = (CB+1)'(pr_r);
      2'd1:    op_den = (CB+1)'(tg_r);
      default: op_den = union_cnt;
    endcase
  end
  assign ratio_special = (op_den == '0) || ((CB+1)'(tp_r) >= op_den);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_CLEAR:   if (clr == LAST_ADDR) state_next = BK_IDLE;
      BK_IDLE: begin
        if (q_valid) state_next = (q_item.kind == KIND_ACCUM) ? BK_ACC : BK_F_READ;
      end
      BK_ACC:     if (t == LAST_T) state_next = BK_IDLE;
      BK_F_READ:  state_next = (c >= class_limit) ? BK_F_MEAN : BK_F_LOAD;
      BK_F_LOAD:  state_next = (tgt_q == '0) ? BK_F_READ : BK_F_RATIO;
      BK_F_RATIO: begin
        if (!ratio_special) state_next = BK_F_RWAIT;
        else if (op == 2'd2) state_next = BK_F_READ;
      end
      BK_F_RWAIT: if (div_done) state_next = (op == 2'd2) ? BK_F_READ : BK_F_RATIO;
      BK_F_MEAN: begin
        if (vcnt == '0) state_next = BK_F_NEXT;
        else if (mop == 2'd3 && pr_sum == '0) state_next = BK_F_NEXT;
        else state_next = BK_F_MWAIT;
      end
      BK_F_MWAIT: if (div_done) state_next = (mop == 2'd3) ? BK_F_NEXT : BK_F_MEAN;
      BK_F_NEXT:  state_next = (t == LAST_T) ? BK_F_ACC : BK_F_READ;
      BK_F_ACC:   state_next = acc_div ? BK_F_AWAIT : BK_F_EMIT;
      BK_F_AWAIT: if (div_done) state_next = BK_F_EMIT;
      BK_F_EMIT:  if (res_ready) state_next = BK_CLEAR;
      default:    state_next = BK_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop       = 1'b0;
    res_valid   = 1'b0;
    div_start   = 1'b0;
    div_num     = NW'({tp_r, 16'h0000});
    div_den     = DW'(op_den);
    rd_addr     = base + AW'(c);
    tgt_rd_addr = CW'(c);
    unique case (state)
      BK_IDLE:    q_pop = q_valid;
      BK_ACC: begin
        rd_addr     = acc_addr;
        tgt_rd_addr = acc_cls;
      end
      BK_F_RATIO: div_start = !ratio_special;
      BK_F_MEAN: begin
        if (mop == 2'd3) begin
          div_start = (vcnt != '0) && (pr_sum != '0);
          div_num   = NW'({pr_prod[32:0], 1'b0});
          div_den   = DW'(pr_sum);
        end else begin
          div_start = (vcnt != '0);
          div_num   = NW'(sums[mop]);
          div_den   = DW'(vcnt);
        end
      end
      BK_F_ACC: begin
        div_start = acc_div;
        div_num   = NW'({m_sel, 16'h0000});
        div_den   = DW'(total);
      end
      BK_F_EMIT:  res_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= BK_CLEAR;
    else state <= state_next;
  end

  // count memories: one read and one write port each
  assign wr_en       = pw_en || (state == BK_CLEAR);
  assign wr_addr     = (state == BK_CLEAR) ? clr : pw_addr;
  assign wr_data     = (state == BK_CLEAR) ? '0 :
                       {(pw_tp && mem_tp != CNT_MAX) ? mem_tp + 1'b1 : mem_tp,
                        (mem_pr != CNT_MAX) ? mem_pr + 1'b1 : mem_pr};
  assign tgt_wr_en   = tg_pend || ((state == BK_CLEAR) && (32'(clr) < MC));
  assign tgt_wr_addr = (state == BK_CLEAR) ? CW'(clr) : acc_cls;
  assign tgt_wr_data = (state == BK_CLEAR) ? '0 :
                       ((tgt_q != CNT_MAX) ? tgt_q + 1'b1 : tgt_q);

  always_ff @(posedge clk) begin
    mem_q <= cnt_mem[rd_addr];
    if (wr_en) cnt_mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    tgt_q <= tgt_mem[tgt_rd_addr];
    if (tgt_wr_en) tgt_mem[tgt_wr_addr] <= tgt_wr_data;
  end

  // write-back stage of the per-threshold read-modify-write
  always_ff @(posedge clk) begin
    if (rst) begin
      pw_en   <= 1'b0;
      tg_pend <= 1'b0;
    end else begin
      pw_en   <= (state == BK_ACC) && pred;
      tg_pend <= (state == BK_ACC) && (t == '0) && acc_tgt;
    end
  end

  always_ff @(posedge clk) begin
    pw_addr <= acc_addr;
    pw_tp   <= acc_tgt;
  end

  // match counters and element total
  always_ff @(posedge clk) begin
    if (rst || (state == BK_F_EMIT && res_ready)) begin
      for (int i = 0; i < T; i++) match[i] <= '0;
      total <= '0;
    end else begin
      if (state == BK_IDLE && q_valid && q_item.kind == KIND_ACCUM && total != CNT_MAX) begin
        total <= total + 1'b1;
      end
      if (state == BK_ACC && pred == acc_tgt && match[TIW'(t)] != CNT_MAX) begin
        match[TIW'(t)] <= match[TIW'(t)] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else if (state == BK_CLEAR) begin
      clr <= clr + 1'b1;
    end else if (state == BK_F_EMIT) begin
      clr <= '0;
    end
  end

  // sweep and evaluation datapath
  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          t <= '0;
          if (q_item.kind == KIND_ACCUM) begin
            acc_prob <= prob_m;
            acc_tgt  <= q_item.tgt;
            acc_cls  <= CW'(q_item.cls);
            acc_addr <= AW'(q_item.cls);
            thr      <= thr_init;
          end else begin
            base     <= '0;
            c        <= '0;
            vcnt     <= '0;
            found    <= 1'b0;
            best_idx <= MID;
            for (int i = 0; i < 3; i++) sums[i] <= '0;
            for (int i = 0; i < 4; i++) best[i] <= '0;
          end
        end
      end
      BK_ACC: begin
        acc_addr <= acc_addr + MC_STEP;
        thr      <= thr_adv;
        t        <= t + 1'b1;
      end
      BK_F_READ: mop <= '0;
      BK_F_LOAD: begin
        tp_r <= tp_min;
        pr_r <= mem_pr;
        tg_r <= tgt_q;
        op   <= '0;
        if (tgt_q == '0) c <= c + 1'b1;
      end
      BK_F_RATIO: begin
        if (ratio_special) begin
          sums[op] <= sums[op] + SW'(ONE_Q16);
          if (op == 2'd2) begin
            vcnt <= vcnt + 1'b1;
            c    <= c + 1'b1;
          end else begin
            op <= op + 1'b1;
          end
        end
      end
      BK_F_RWAIT: begin
        if (div_done) begin
          sums[op] <= sums[op] + SW'(div_quot[16:0]);
          if (op == 2'd2) begin
            vcnt <= vcnt + 1'b1;
            c    <= c + 1'b1;
          end else begin
            op <= op + 1'b1;
          end
        end
      end
      BK_F_MEAN: begin
        if (vcnt == '0) begin
          for (int i = 0; i < 4; i++) means[i] <= '0;
        end else if (mop == 2'd3 && pr_sum == '0) begin
          means[3] <= '0;
        end
      end
      BK_F_MWAIT: begin
        if (div_done) begin
          means[mop] <= div_quot[16:0];
          mop        <= mop + 1'b1;
        end
      end
      BK_F_NEXT: begin
        // the middle index is taken unless a strictly better f1 came first; a later strictly better f1 still wins
        if (better || (t == MID && !found)) begin
          for (int i = 0; i < 4; i++) best[i] <= means[i];
          best_idx <= t;
        end
        if (better) found <= 1'b1;
        if (t != LAST_T) begin
          t    <= t + 1'b1;
          base <= base + MC_STEP;
          c    <= '0;
          vcnt <= '0;
          for (int i = 0; i < 3; i++) sums[i] <= '0;
        end
      end
      BK_F_ACC: begin
        chosen_thr <= (thr_lim > XW'(16'hFFFF)) ? 16'hFFFF : thr_lim[15:0];
        if (total == '0) acc_q <= '0;
        else if (!acc_div) acc_q <= ONE_Q16;
      end
      BK_F_AWAIT: if (div_done) acc_q <= div_quot[16:0];
      default: ;
    endcase
  end

  always_comb begin
    res.mean_iou         = sat16(best[2]);
    res.mean_precision   = sat16(best[0]);
    res.mean_recall      = sat16(best[1]);
    res.f1_score         = sat16(best[3]);
    res.pixel_accuracy   = sat16(acc_q);
    res.chosen_threshold = chosen_thr;
    res.chosen_index     = best_idx;
    res.any_valid        = (vcnt != '0);
  end

endmodule

>>> hw/rtl/tss_checker.sv
// port-level checks on the result channel of the metrics block
// depends on tss_pkg; bound to threshold_sweep_segmentation_metrics below
module tss_checker #(
  parameter int THRESHOLD_COUNT = tss_pkg::THRESHOLD_COUNT_DEF
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [tss_pkg::OUT_TDATA_BITS-1:0] m_tdata
);
  import tss_pkg::*;

  localparam logic [4:0] LAST_T = 5'(THRESHOLD_COUNT - 1);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_no_class: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[101] |-> m_tdata[63:0] == 64'd0)
    else $error("class metrics nonzero with no valid class");

  a_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[100:96] <= LAST_T)
    else $error("chosen index beyond sweep");

  // harmonic mean never exceeds the larger of its two inputs
  a_f1: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[63:48] <= m_tdata[31:16]) || (m_tdata[63:48] <= m_tdata[47:32]))
    else $error("f1 above both precision and recall");

endmodule

bind threshold_sweep_segmentation_metrics tss_checker #(
  .THRESHOLD_COUNT (THRESHOLD_COUNT)
) u_tss_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> test/tb_threshold_sweep_segmentation_metrics.sv
// testbench for threshold_sweep_segmentation_metrics: directed beats and random element streams with
// finish beats, checked against a local metrics predictor; depends on tss_pkg
`timescale 1ns / 1ps

import tss_pkg::*;

class metrics_scoreboard;
  localparam int NT = THRESHOLD_COUNT_DEF;
  localparam int NC = MAX_CLASSES_DEF;
  localparam longint unsigned CMAX = 64'hFFFF_FFFF;

  bit [4:0]  class_cnt;
  bit [15:0] thr_start;
  bit [15:0] thr_stride;
  longint unsigned tp_cnt[NT][NC];
  longint unsigned pred_cnt[NT][NC];
  longint unsigned tgt_cnt[NC];
  longint unsigned match_cnt[NT];
  longint unsigned elem_total;
  result_t expected_results[$];
  int mismatches;

  function new();
    class_cnt  = CLASS_COUNT_RST;
    thr_start  = THR_START_RST;
    thr_stride = THR_STRIDE_RST;
    mismatches = 0;
    clear_counts();
  endfunction

  function void clear_counts();
    for (int t = 0; t < NT; t++) begin
      match_cnt[t] = 0;
      for (int c = 0; c < NC; c++) begin
        tp_cnt[t][c] = 0;
        pred_cnt[t][c] = 0;
      end
    end
    for (int c = 0; c < NC; c++) tgt_cnt[c] = 0;
    elem_total = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [15:0] val);
    case (idx)
      CFG_CLASS_COUNT: class_cnt  = val[4:0];
      CFG_THR_START:   thr_start  = val;
      CFG_THR_STRIDE:  thr_stride = val;
      default: ;
    endcase
  endfunction

  function longint unsigned thr_at(int t);
    longint unsigned v;
    v = longint'(thr_start) + longint'(t) * longint'(thr_stride);
    return (v > 65535) ? 65535 : v;
  endfunction

  function int active_classes();
    return (class_cnt > NC) ? NC : class_cnt;
  endfunction

  static function longint unsigned frac_q16(longint unsigned num, longint unsigned den);
    if (den == 0 || num >= den) return 65536;
    return (num << 16) / den;
  endfunction

  static function void bump(ref longint unsigned c);
    if (c < CMAX) c++;
  endfunction

  // macro metrics at one threshold, returns number of classes with targets
  function int metrics_at(int t, output longint unsigned iou, output longint unsigned p,
                          output longint unsigned r, output longint unsigned f);
    longint unsigned si, sp, sr, tp, pr, tg;
    int valid;
    si = 0; sp = 0; sr = 0; valid = 0;
    iou = 0; p = 0; r = 0; f = 0;
    for (int c = 0; c < active_classes(); c++) begin
      tp = tp_cnt[t][c];
      pr = pred_cnt[t][c];
      tg = tgt_cnt[c];
      if (tg == 0) continue;
      if (tp > pr) tp = pr;
      if (tp > tg) tp = tg;
      sp += frac_q16(tp, pr);
      sr += frac_q16(tp, tg);
      si += frac_q16(tp, pr + tg - tp);
      valid++;
    end
    if (valid > 0) begin
      iou = si / valid;
      p = sp / valid;
      r = sr / valid;
      f = (p + r == 0) ? 0 : (2 * p * r) / (p + r);
    end
    return valid;
  endfunction

  static function logic [15:0] clip16(longint unsigned v);
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  function void note_input(item_t it);
    int best, valid;
    longint unsigned best_f1, iou, p, r, f, acc;
    bit pred;
    result_t res;
    if (it.kind == KIND_ACCUM) begin
      if (it.cls >= active_classes()) return;
      if (it.tgt) bump(tgt_cnt[it.cls]);
      bump(elem_total);
      for (int t = 0; t < NT; t++) begin
        pred = it.prob > thr_at(t);
        if (pred) begin
          bump(pred_cnt[t][it.cls]);
          if (it.tgt) bump(tp_cnt[t][it.cls]);
        end
        if (pred == it.tgt) bump(match_cnt[t]);
      end
    end else begin
      best = NT / 2;
      best_f1 = 0;
      for (int t = 0; t < NT; t++)
        if (metrics_at(t, iou, p, r, f) > 0 && f > best_f1) begin
          best_f1 = f;
          best = t;
        end
      valid = metrics_at(best, iou, p, r, f);
      acc = (elem_total == 0) ? 0 : frac_q16(match_cnt[best], elem_total);
      res.mean_iou         = clip16(iou);
      res.mean_precision   = clip16(p);
      res.mean_recall      = clip16(r);
      res.f1_score         = clip16(f);
      res.pixel_accuracy   = clip16(acc);
      res.chosen_threshold = clip16(thr_at(best));
      res.chosen_index     = best[4:0];
      res.any_valid        = (valid > 0);
      expected_results.push_back(res);
      clear_counts();
    end
  endfunction

  function void check_result(result_t got);
    result_t exp_r;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result beat %h", got);
      return;
    end
    exp_r = expected_results.pop_front();
    if (got !== exp_r) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("result mismatch (exp/got): iou %0d/%0d prec %0d/%0d rec %0d/%0d",
                 exp_r.mean_iou, got.mean_iou, exp_r.mean_precision, got.mean_precision,
                 exp_r.mean_recall, got.mean_recall);
        $display("  f1 %0d/%0d acc %0d/%0d thr %0d/%0d idx %0d/%0d valid %0d/%0d",
                 exp_r.f1_score, got.f1_score,
                 exp_r.pixel_accuracy, got.pixel_accuracy,
                 exp_r.chosen_threshold, got.chosen_threshold,
                 exp_r.chosen_index, got.chosen_index, exp_r.any_valid, got.any_valid);
      end
    end
  endfunction
endclass

module tb_threshold_sweep_segmentation_metrics;
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_BITS-1:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  metrics_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;

  threshold_sweep_segmentation_metrics uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver: random stalls, plus a long hold-off when hold_left is set
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk)
    if (!rst && m_tvalid && m_tready) sb.check_result(result_t'(m_tdata[101:0]));

  task automatic send_beat(kind_t kind, logic [15:0] prob, logic tgt, logic [3:0] cls);
    item_t it;
    it.kind = kind;
    it.prob = prob;
    it.tgt  = tgt;
    it.cls  = cls;
    s_tdata  <= {3'b000, cls, tgt, prob};
    s_tuser  <= kind;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(it);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [15:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
  endtask

  // drain all results, then let the back end finish its clear pass
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic run_phase(int n_items, int finish_pct);
    int t, off;
    logic [15:0] prob;
    logic [3:0] cls;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(99) < finish_pct) begin
        send_beat(KIND_FINISH, 16'($urandom), 1'($urandom), 4'($urandom));
      end else begin
        if ($urandom_range(99) < 50) begin
          prob = 16'($urandom);
        end else begin
          // land near a threshold to hit the strict compare
          t = $urandom_range(THRESHOLD_COUNT_DEF - 1);
          off = $urandom_range(2);
          prob = 16'(sb.thr_at(t) + off - 1);
        end
        if (sb.active_classes() > 0 && $urandom_range(99) < 85)
          cls = 4'($urandom_range(sb.active_classes() - 1));
        else
          cls = 4'($urandom);
        send_beat(KIND_ACCUM, prob, 1'($urandom), cls);
      end
    end
    send_beat(KIND_FINISH, 16'($urandom), 1'($urandom), 4'($urandom));
    drain();
  endtask

  initial begin
    #200_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    repeat (600) @(posedge clk);

    // directed: empty finish, boundary probabilities, ignored register write
    send_beat(KIND_FINISH, 16'hFFFF, 1'b1, 4'hF);
    send_beat(KIND_ACCUM, 16'd6554, 1'b1, 4'd0);
    send_beat(KIND_ACCUM, 16'd6555, 1'b0, 4'd0);
    send_beat(KIND_ACCUM, 16'd0, 1'b1, 4'd1);
    send_beat(KIND_FINISH, 16'h0, 1'b0, 4'h0);
    drain();
    write_cfg(2'd3, 16'hFFFF);
    write_cfg(CFG_CLASS_COUNT, 16'd16);
    send_beat(KIND_ACCUM, 16'd0, 1'b1, 4'd0);
    send_beat(KIND_ACCUM, 16'hFFFF, 1'b0, 4'd15);
    send_beat(KIND_ACCUM, 16'hFFFF, 1'b1, 4'd3);
    send_beat(KIND_ACCUM, 16'hAAAA, 1'b1, 4'd15);
    send_beat(KIND_ACCUM, 16'h5555, 1'b0, 4'd7);
    send_beat(KIND_FINISH, 16'h1234, 1'b1, 4'd9);
    drain();
    write_cfg(CFG_CLASS_COUNT, 16'd0);
    send_beat(KIND_ACCUM, 16'hFFFF, 1'b1, 4'd0);
    send_beat(KIND_FINISH, 16'h0, 1'b0, 4'd0);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      case (ph / 4)
        0: begin send_idle_pct = 26; recv_idle_pct = 81; end
        1: begin send_idle_pct = 81; recv_idle_pct = 26; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (ph)
        0: begin
          write_cfg(CFG_CLASS_COUNT, 16'd2);
          write_cfg(CFG_THR_START, 16'd0);
          write_cfg(CFG_THR_STRIDE, 16'd0);
        end
        1: begin
          write_cfg(CFG_CLASS_COUNT, 16'd16);
          write_cfg(CFG_THR_START, 16'hFFFF);
          write_cfg(CFG_THR_STRIDE, 16'hFFFF);
        end
        2: write_cfg(CFG_CLASS_COUNT, 16'd0);
        5: begin
          // upper bits of the class count are dropped, 31 acts as 16
          write_cfg(CFG_CLASS_COUNT, 16'hFFFF);
          write_cfg(CFG_THR_START, 16'd1000);
          write_cfg(CFG_THR_STRIDE, 16'd4000);
        end
        default: begin
          write_cfg(CFG_CLASS_COUNT, 16'($urandom_range(1, 5)));
          write_cfg(CFG_THR_START, 16'($urandom_range(0, 40000)));
          write_cfg(CFG_THR_STRIDE, 16'($urandom_range(0, 4000)));
        end
      endcase
      if (ph == 6) begin
        send_beat(KIND_FINISH, 16'h0, 1'b0, 4'd0);
        hold_left = 40000;
      end
      if (ph == 1 || ph == 5) run_phase(60, 2);
      else run_phase(130, 3);
    end

    s_tvalid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_results.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule
